// ===== rtl/frame_timestamp_matcher_defines.svh =====
// Assertion macros shared by the frame timestamp matcher RTL.
// Standalone header; the assertion macros expect clk and rst in the using module.
`ifndef FRAME_TIMESTAMP_MATCHER_DEFINES_SVH
`define FRAME_TIMESTAMP_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define FTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset
`define FTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FTM_ASSERT_NOW(lbl, ante, cons, msg)
`define FTM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/ftm_pkg.sv =====
// Types and constants for the frame timestamp matcher.
// No dependencies; imported by every module of the block.
package ftm_pkg;

  // Input action codes
  localparam logic [1:0] ACT_COMPARE = 2'd0;
  localparam logic [1:0] ACT_TSYNC   = 2'd1;
  localparam logic [1:0] ACT_FSYNC   = 2'd2;

  // Verdict codes
  localparam logic [1:0] VER_MATCH      = 2'd0;
  localparam logic [1:0] VER_DROP_FRAME = 2'd1;
  localparam logic [1:0] VER_DROP_STAMP = 2'd2;

  // Configuration register indexes
  localparam int          CFG_IDX_W       = 3;
  localparam int          CFG_DATA_W      = 21;
  localparam logic [2:0]  REG_MATCH_MODE  = 3'd0;
  localparam logic [2:0]  REG_LOWER_ERROR = 3'd1;
  localparam logic [2:0]  REG_UPPER_ERROR = 3'd2;
  localparam logic [2:0]  REG_INNER_LOWER = 3'd3;
  localparam logic [2:0]  REG_INNER_UPPER = 3'd4;

  // Register reset values (0.1 ms units)
  localparam logic [20:0] LOWER_ERROR_RST = 21'h1FFF9C;  // -100
  localparam logic [19:0] UPPER_ERROR_RST = 20'd100;
  localparam logic [20:0] INNER_LOWER_RST = 21'h1FFFCE;  // -50
  localparam logic [19:0] INNER_UPPER_RST = 20'd50;

  // Divider length: one quotient bit per step over the 48-bit total
  localparam int DIV_STEPS = 48;

  typedef struct packed {
    logic        match_mode;
    logic [20:0] lower_error;
    logic [19:0] upper_error;
    logic [20:0] inner_lower;
    logic [19:0] inner_upper;
  } cfg_t;

  // Work class decided at the front
  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_TSYNC,
    KIND_FSYNC,
    KIND_BOGUS,
    KIND_TIME,
    KIND_FID
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] frame_id;
    logic [20:0] camera_ticks;
    logic [31:0] timestamp_id;
    logic [43:0] device_ticks;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_ELAP,
    ST_OFF,
    ST_DIFF,
    ST_JUDGE,
    ST_DIV,
    ST_DONE
  } back_state_t;

endpackage

// ===== rtl/frame_timestamp_matcher.sv =====
// Frame timestamp matcher top level: configuration registers, front queue, back sequencer.
// Depends on ftm_pkg, ftm_front and ftm_back.
//
// Each input word yields exactly one output word with the verdict, the corrected
// clock difference and the correction in force after the word. The front queue
// holds two words so input keeps flowing while the back end works; the back end
// handles one word at a time. Sync, unused, id-0/ticks-0 and frame-id mismatch
// words go from execute straight to done; a frame-id match also passes multiply,
// elapsed and offset, and a timestamp compare adds difference and judge. A
// timestamp match that sets a new correction from accumulated offsets also runs
// the serial 48-step divider. The output register frees the back end once it is
// empty or its word is taken; m_tready low holds the back end in its final step.
module frame_timestamp_matcher import ftm_pkg::*; #(
  parameter int CYCLE_TICKS = 1280000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // frame_id [31:0], camera_ticks [52:32], timestamp_id [84:53], device_ticks [128:85]
  input  logic [135:0]          s_tdata,
  // action [1:0]
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // verdict [1:0], diff_ticks [49:2], correction_ticks [81:50]
  output logic [87:0]           m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg;
  logic   q_valid;
  entry_t q_head;
  logic   q_pop;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_mode  <= 1'b0;
      cfg.lower_error <= LOWER_ERROR_RST;
      cfg.upper_error <= UPPER_ERROR_RST;
      cfg.inner_lower <= INNER_LOWER_RST;
      cfg.inner_upper <= INNER_UPPER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATCH_MODE:  cfg.match_mode  <= cfg_wdata[0];
        REG_LOWER_ERROR: cfg.lower_error <= cfg_wdata[20:0];
        REG_UPPER_ERROR: cfg.upper_error <= cfg_wdata[19:0];
        REG_INNER_LOWER: cfg.inner_lower <= cfg_wdata[20:0];
        REG_INNER_UPPER: cfg.inner_upper <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  ftm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .match_mode (cfg.match_mode),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  ftm_back #(
    .CYCLE_TICKS (CYCLE_TICKS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/ftm_front.sv =====
// Front end: accepts input words, classifies them and queues them.
// Depends on ftm_pkg for the entry and kind types.
module ftm_front import ftm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // frame_id [31:0], camera_ticks [52:32], timestamp_id [84:53], device_ticks [128:85]
  input  logic [135:0] s_tdata,
  // action [1:0]
  input  logic [1:0]   s_tuser,
  input  logic         match_mode,
  output logic         q_valid,
  output entry_t       q_head,
  input  logic         q_pop
);

  entry_t     slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  entry_t     incoming;

  // Classify the incoming word
  always_comb begin
    incoming.frame_id     = s_tdata[31:0];
    incoming.camera_ticks = s_tdata[52:32];
    incoming.timestamp_id = s_tdata[84:53];
    incoming.device_ticks = s_tdata[128:85];
    unique case (s_tuser)
      ACT_TSYNC: incoming.kind = KIND_TSYNC;
      ACT_FSYNC: incoming.kind = KIND_FSYNC;
      ACT_COMPARE: begin
        if ((s_tdata[31:0] == 32'd0) && (s_tdata[52:32] == 21'd0)) begin
          incoming.kind = KIND_BOGUS;
        end else if (match_mode) begin
          incoming.kind = KIND_FID;
        end else begin
          incoming.kind = KIND_TIME;
        end
      end
      default: incoming.kind = KIND_NOP;
    endcase
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_head   = slot[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/ftm_div.sv =====
// Serial signed divider for the correction average, one quotient bit per cycle.
// Depends on ftm_pkg for the step count.
module ftm_div import ftm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  localparam int CntW = $clog2(DIV_STEPS);
  localparam logic [CntW-1:0] LastStep = CntW'(DIV_STEPS - 1);

  logic            busy;
  logic [CntW-1:0] step;
  logic [47:0]     acc;
  logic [31:0]     rem;
  logic [31:0]     dvs;
  logic            neg;
  logic [32:0]     rem_sh;
  logic            fits;
  logic [32:0]     rem_sub;
  logic [47:0]     mag;

  // Restoring step on magnitudes
  assign mag     = dividend[47] ? (48'd0 - dividend) : dividend;
  assign rem_sh  = {rem, acc[47]};
  assign fits    = (rem_sh >= {1'b0, dvs});
  assign rem_sub = rem_sh - {1'b0, dvs};

  // Apply the dividend sign; the divisor is always positive
  assign quotient = neg ? (32'd0 - acc[31:0]) : acc[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LastStep);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LastStep) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Shift quotient bits into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= mag;
      rem <= 32'd0;
      dvs <= divisor;
      neg <= dividend[47];
    end else if (busy) begin
      rem <= fits ? rem_sub[31:0] : rem_sh[31:0];
      acc <= {acc[46:0], fits};
    end
  end

endmodule

// ===== rtl/ftm_back.sv =====
// Back end: sequences queued words through the clock arithmetic and match logic.
// Depends on ftm_pkg, ftm_div and the assertion macro header.
`include "frame_timestamp_matcher_defines.svh"

module ftm_back import ftm_pkg::*; #(
  parameter int CYCLE_TICKS = 1280000
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         q_valid,
  input  entry_t       q_head,
  output logic         q_pop,
  output logic         m_tvalid,
  input  logic         m_tready,
  // verdict [1:0], diff_ticks [49:2], correction_ticks [81:50]
  output logic [87:0]  m_tdata
);

  localparam logic [21:0] CycTicks = 22'(CYCLE_TICKS);

  back_state_t state, state_next;
  entry_t      item;

  logic [31:0] frame_sync_id;
  logic [31:0] stamp_sync_id;
  logic [20:0] camera_sync_ticks;
  logic [47:0] device_sync_ticks;
  logic [20:0] last_camera_ticks;
  logic [31:0] wrap_cycles;
  logic [31:0] correction;
  logic [47:0] offset_total;
  logic [31:0] offset_count;
  logic [2:0]  sync_flags;

  logic [47:0] prod;
  logic [47:0] dev10;
  logic [47:0] eh;
  logic [47:0] ef;
  logic [47:0] off;
  logic [47:0] diff;
  logic [1:0]  res_verdict;
  logic [47:0] res_diff;

  logic [1:0]  out_verdict;
  logic [47:0] out_diff;
  logic [31:0] out_corr;

  logic        out_free;
  logic        out_load;
  logic [53:0] prod_full;
  logic [31:0] adj_id;
  logic        adj_lt;
  logic        adj_gt;
  logic        d_low;
  logic        d_high;
  logic        d_outer;
  logic        need_div;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;
  logic [2:0]  flags_ts;
  logic [2:0]  flags_fs;

  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = (state == ST_DONE) && out_free;
  assign prod_full = 54'(wrap_cycles) * 54'(CycTicks);
  assign adj_id    = item.frame_id - frame_sync_id + stamp_sync_id;
  assign adj_lt    = $signed(adj_id) < $signed(item.timestamp_id);
  assign adj_gt    = $signed(adj_id) > $signed(item.timestamp_id);
  assign flags_ts  = sync_flags | 3'b001;
  assign flags_fs  = sync_flags | 3'b010;

  // Threshold compares on the corrected difference
  assign d_low   = $signed(diff) < $signed({{27{cfg.lower_error[20]}}, cfg.lower_error});
  assign d_high  = $signed(diff) > $signed({28'd0, cfg.upper_error});
  assign d_outer = ($signed(diff) < $signed({{27{cfg.inner_lower[20]}}, cfg.inner_lower}))
                || ($signed(diff) > $signed({28'd0, cfg.inner_upper}));
  assign need_div = !d_low && !d_high && d_outer && (offset_count != 32'd0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if ((item.kind == KIND_TIME) || ((item.kind == KIND_FID) && !adj_lt && !adj_gt)) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MUL:   state_next = ST_ELAP;
      ST_ELAP:  state_next = ST_OFF;
      ST_OFF:   state_next = (item.kind == KIND_FID) ? ST_DONE : ST_DIFF;
      ST_DIFF:  state_next = ST_JUDGE;
      ST_JUDGE: state_next = need_div ? ST_DIV : ST_DONE;
      ST_DIV:   if (div_done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop     = (state == ST_IDLE) && q_valid;
    div_start = (state == ST_JUDGE) && need_div;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sync_id     <= 32'd0;
      stamp_sync_id     <= 32'd0;
      camera_sync_ticks <= 21'd0;
      device_sync_ticks <= 48'd0;
      last_camera_ticks <= 21'd0;
      wrap_cycles       <= 32'd0;
      correction        <= 32'd0;
      offset_total      <= 48'd0;
      offset_count      <= 32'd0;
      sync_flags        <= 3'd0;
    end else begin
      unique case (state)
        ST_EXEC: begin
          priority case (item.kind)
            KIND_TSYNC: begin
              stamp_sync_id     <= item.timestamp_id;
              device_sync_ticks <= {4'd0, item.device_ticks};
              sync_flags        <= flags_ts;
              if ((flags_ts[1:0] == 2'b11) && !sync_flags[2]) begin
                sync_flags   <= flags_ts | 3'b100;
                correction   <= 32'd0;
                offset_total <= 48'd0;
                offset_count <= 32'd0;
              end
            end
            KIND_FSYNC: begin
              frame_sync_id     <= item.frame_id;
              camera_sync_ticks <= item.camera_ticks;
              last_camera_ticks <= item.camera_ticks;
              wrap_cycles       <= 32'd0;
              sync_flags        <= flags_fs;
              if ((flags_fs[1:0] == 2'b11) && !sync_flags[2]) begin
                sync_flags   <= flags_fs | 3'b100;
                correction   <= 32'd0;
                offset_total <= 48'd0;
                offset_count <= 32'd0;
              end
            end
            KIND_TIME, KIND_FID: begin
              // Track camera cycle wraps; frame-id mode only on an id match
              if ((item.kind == KIND_TIME) || (!adj_lt && !adj_gt)) begin
                if (last_camera_ticks > item.camera_ticks) begin
                  wrap_cycles <= wrap_cycles + 32'd1;
                end
                last_camera_ticks <= item.camera_ticks;
              end
            end
            default: ;
          endcase
        end
        ST_JUDGE: begin
          if (!d_low && !d_high) begin
            if (!d_outer) begin
              offset_total <= offset_total + off;
              offset_count <= offset_count + 32'd1;
            end else if (offset_count == 32'd0) begin
              correction   <= off[31:0];
              offset_total <= 48'd0;
              offset_count <= 32'd0;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            correction   <= div_q;
            offset_total <= 48'd0;
            offset_count <= 32'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          item <= q_head;
        end
      end
      ST_EXEC: begin
        res_diff <= 48'd0;
        priority case (item.kind)
          KIND_BOGUS: res_verdict <= VER_DROP_FRAME;
          KIND_FID: begin
            if (adj_lt) begin
              res_verdict <= VER_DROP_FRAME;
            end else if (adj_gt) begin
              res_verdict <= VER_DROP_STAMP;
            end else begin
              res_verdict <= VER_MATCH;
            end
          end
          default: res_verdict <= VER_MATCH;
        endcase
      end
      ST_MUL: begin
        prod  <= prod_full[47:0];
        dev10 <= ({4'd0, item.device_ticks} << 3) + ({4'd0, item.device_ticks} << 1);
      end
      ST_ELAP: begin
        eh <= dev10 - device_sync_ticks;
        ef <= prod + {27'd0, item.camera_ticks} - {27'd0, camera_sync_ticks};
      end
      ST_OFF: begin
        off      <= eh - ef;
        res_diff <= eh - ef;
      end
      ST_DIFF: begin
        diff <= off - {{16{correction[31]}}, correction};
      end
      ST_JUDGE: begin
        res_diff <= diff;
        if (d_low) begin
          res_verdict <= VER_DROP_STAMP;
        end else if (d_high) begin
          res_verdict <= VER_DROP_FRAME;
        end else begin
          res_verdict <= VER_MATCH;
        end
      end
      default: ;
    endcase
  end

  // Output register: load the finished word when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_verdict <= res_verdict;
      out_diff    <= res_diff;
      out_corr    <= correction;
    end
  end

  assign m_tdata = {6'd0, out_corr, out_diff, out_verdict};

  ftm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset_total),
    .divisor  (offset_count),
    .done     (div_done),
    .quotient (div_q)
  );

  `FTM_ASSERT_NOW(a_sync_order, sync_flags[2], sync_flags[1:0] == 2'b11, "early sync flag")
  `FTM_ASSERT_NOW(a_div_count, state == ST_DIV, offset_count != 32'd0, "average of no offsets")
  `FTM_ASSERT_NEXT(a_done_load, out_load, m_tvalid && (state == ST_IDLE), "word not loaded")

endmodule
